[hdl/tes_pkg.sv]
// ----------------------------------------------------------------------------
// tes_pkg
// Shared widths and cell payload types for the truss element stiffness core.
// ----------------------------------------------------------------------------
package tes_pkg;

    localparam int MAG_W     = 33;
    localparam int RAD_W     = 68;
    localparam int ROOT_W    = 34;
    localparam int REM_W     = 36;
    localparam int DIV_W     = 64;
    localparam int COS_BITS  = 30;
    localparam int COS_W     = 31;
    localparam int PROD_W    = 62;
    localparam int SQ_CELLS  = 34;
    localparam int DIV_CELLS = 64;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [MAG_W-1:0]  ax;
        logic [MAG_W-1:0]  ay;
        logic [DIV_W-1:0]  ea;
        logic              neg;
    } sq_t;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic [ROOT_W-1:0] rk;
        logic [ROOT_W-1:0] rc;
        logic [ROOT_W-1:0] rs;
        logic [DIV_W-1:0]  dk;
        logic [DIV_W-1:0]  dc;
        logic [DIV_W-1:0]  ds;
        logic              neg;
    } dv_t;

endpackage

[hdl/truss_element_stiffness_core.sv]
// ----------------------------------------------------------------------------
// truss_element_stiffness_core
// Plane truss bar element: length and the three distinct global stiffness
// entries k*c*c, k*c*s, k*s*s from node coordinates, modulus and area.
// ----------------------------------------------------------------------------
// Pipeline: 2 prep stages, 34 square root cells, 64 divider cells,
//   1 cosine product stage, 3 entry stages.
// Throughput: one transaction per cycle; the whole pipeline holds when the
//   output register is full and m_tready is low.
// Reset: synchronous aresetn clears all stage valid bits.
module truss_element_stiffness_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_x, first_y, second_x, second_y, modulus, section_area
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bar_length, k_cc, k_cs, k_ss, zero_length, saturated, 5 zero bits
    output logic [231:0] m_tdata
);

    logic                          en;
    logic [32:0]                   dx, dy;
    logic                          p0_vld_reg, p1_vld_reg;
    logic [tes_pkg::MAG_W-1:0]     ax_reg, ay_reg, ax1_reg, ay1_reg;
    logic [tes_pkg::DIV_W-1:0]     ea_reg, ea1_reg;
    logic                          neg_reg, neg1_reg;
    logic [65:0]                   sum_next;
    logic [65:0]                   sum_reg;
    tes_pkg::sq_t                  sq_d [0:tes_pkg::SQ_CELLS];
    logic                          sq_v [0:tes_pkg::SQ_CELLS];
    tes_pkg::dv_t                  dv_d [0:tes_pkg::DIV_CELLS];
    logic                          dv_v [0:tes_pkg::DIV_CELLS];
    tes_pkg::dv_t                  dv_last;
    logic                          pp_vld_reg;
    logic [tes_pkg::DIV_W-1:0]     k_reg;
    logic [tes_pkg::PROD_W-1:0]    pcc_reg, pcs_reg, pss_reg;
    logic                          pneg_reg;
    logic [tes_pkg::COS_W-1:0]     cq, sq;
    logic                          zl_next;
    logic [2:0]                    e_vld_reg;
    logic [32:0]                   len_reg [0:3];
    logic                          zl_reg  [0:3];
    logic [63:0]                   v_cc, v_cs, v_ss;
    logic                          s_cc, s_cs, s_ss;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        dx = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
        dy = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            pp_vld_reg <= 1'b0;
            e_vld_reg  <= 3'b000;
        end else if (en) begin
            p0_vld_reg <= s_tvalid;
            p1_vld_reg <= p0_vld_reg;
            pp_vld_reg <= dv_v[tes_pkg::DIV_CELLS];
            e_vld_reg  <= {e_vld_reg[1:0], pp_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= dx[32] ? (33'd0 - dx) : dx;
            ay_reg  <= dy[32] ? (33'd0 - dy) : dy;
            neg_reg <= dx[32] ^ dy[32];
            ea_reg  <= s_tdata[159:128] * s_tdata[191:160];
        end
    end

    always_comb begin
        sum_next = ax_reg * ax_reg + ay_reg * ay_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sum_next;
            ax1_reg  <= ax_reg;
            ay1_reg  <= ay_reg;
            ea1_reg  <= ea_reg;
            neg1_reg <= neg_reg;
        end
    end

    always_comb begin
        sq_v[0]      = p1_vld_reg;
        sq_d[0].rad  = {2'b00, sum_reg};
        sq_d[0].rem  = '0;
        sq_d[0].root = '0;
        sq_d[0].ax   = ax1_reg;
        sq_d[0].ay   = ay1_reg;
        sq_d[0].ea   = ea1_reg;
        sq_d[0].neg  = neg1_reg;
    end

    for (genvar i = 0; i < tes_pkg::SQ_CELLS; i++) begin : g_sqrt
        tes_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (sq_v[i]),
            .in_d    (sq_d[i]),
            .out_vld (sq_v[i+1]),
            .out_d   (sq_d[i+1])
        );
    end

    always_comb begin
        dv_v[0]     = sq_v[tes_pkg::SQ_CELLS];
        dv_d[0].len = sq_d[tes_pkg::SQ_CELLS].root;
        dv_d[0].rk  = '0;
        dv_d[0].rc  = '0;
        dv_d[0].rs  = '0;
        dv_d[0].dk  = sq_d[tes_pkg::SQ_CELLS].ea;
        dv_d[0].dc  = {1'b0, sq_d[tes_pkg::SQ_CELLS].ax, {tes_pkg::COS_BITS{1'b0}}};
        dv_d[0].ds  = {1'b0, sq_d[tes_pkg::SQ_CELLS].ay, {tes_pkg::COS_BITS{1'b0}}};
        dv_d[0].neg = sq_d[tes_pkg::SQ_CELLS].neg;
    end

    for (genvar j = 0; j < tes_pkg::DIV_CELLS; j++) begin : g_div
        tes_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_vld  (dv_v[j]),
            .in_d    (dv_d[j]),
            .out_vld (dv_v[j+1]),
            .out_d   (dv_d[j+1])
        );
    end

    always_comb begin
        dv_last = dv_d[tes_pkg::DIV_CELLS];
        cq      = dv_last.dc[tes_pkg::COS_W-1:0];
        sq      = dv_last.ds[tes_pkg::COS_W-1:0];
        zl_next = (dv_last.len == '0);
    end

    // zero length forces k to zero, so all entries and saturation come out zero
    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg      <= zl_next ? '0 : dv_last.dk;
            pcc_reg    <= cq * cq;
            pcs_reg    <= cq * sq;
            pss_reg    <= sq * sq;
            pneg_reg   <= dv_last.neg;
            len_reg[0] <= dv_last.len[32:0];
            zl_reg[0]  <= zl_next;
            for (int n = 1; n < 4; n++) begin
                len_reg[n] <= len_reg[n-1];
                zl_reg[n]  <= zl_reg[n-1];
            end
        end
    end

    tes_entry u_cc (
        .aclk (aclk), .en (en), .k (k_reg), .p (pcc_reg), .neg (1'b0),
        .value (v_cc), .sat (s_cc)
    );

    tes_entry u_cs (
        .aclk (aclk), .en (en), .k (k_reg), .p (pcs_reg), .neg (pneg_reg),
        .value (v_cs), .sat (s_cs)
    );

    tes_entry u_ss (
        .aclk (aclk), .en (en), .k (k_reg), .p (pss_reg), .neg (1'b0),
        .value (v_ss), .sat (s_ss)
    );

    assign m_tvalid = e_vld_reg[2];
    assign m_tdata  = {5'd0, s_cc | s_cs | s_ss, zl_reg[3], v_ss, v_cs, v_cc, len_reg[3]};

    a_zero_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && zl_reg[3] |-> v_cc == '0 && v_cs == '0 && v_ss == '0
                                  && !(s_cc || s_cs || s_ss))
        else $error("zero length bar with nonzero entries");

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && zl_reg[3] |-> len_reg[3] == '0)
        else $error("zero length flag with nonzero length");

    a_diag_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !v_cc[63] && !v_ss[63])
        else $error("diagonal entry negative");

endmodule

[hdl/tes_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// tes_sqrt_cell
// One root bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module tes_sqrt_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  tes_pkg::sq_t  in_d,
    output logic          out_vld,
    output tes_pkg::sq_t  out_d
);

    logic [tes_pkg::REM_W+1:0] r;
    logic [tes_pkg::REM_W+1:0] trial;
    logic [tes_pkg::REM_W+1:0] diff;
    logic                      ge;
    tes_pkg::sq_t              d_next;
    tes_pkg::sq_t              d_reg;
    logic                      vld_reg;

    always_comb begin
        r      = {in_d.rem, in_d.rad[tes_pkg::RAD_W-1 -: 2]};
        trial  = {2'b00, in_d.root, 2'b01};
        diff   = r - trial;
        ge     = (r >= trial);
        d_next = in_d;
        d_next.rem  = ge ? diff[tes_pkg::REM_W-1:0] : r[tes_pkg::REM_W-1:0];
        d_next.root = {in_d.root[tes_pkg::ROOT_W-2:0], ge};
        d_next.rad  = {in_d.rad[tes_pkg::RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_d   = d_reg;

endmodule

[hdl/tes_div_cell.sv]
// ----------------------------------------------------------------------------
// tes_div_cell
// One quotient bit of three restoring divisions sharing the bar length.
// ----------------------------------------------------------------------------
module tes_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_vld,
    input  tes_pkg::dv_t  in_d,
    output logic          out_vld,
    output tes_pkg::dv_t  out_d
);

    logic [tes_pkg::ROOT_W:0] dvs;
    logic [tes_pkg::ROOT_W:0] rk, rc, rs;
    logic [tes_pkg::ROOT_W:0] sk, sc, ss;
    logic                     qk, qc, qs;
    tes_pkg::dv_t             d_next;
    tes_pkg::dv_t             d_reg;
    logic                     vld_reg;

    always_comb begin
        dvs = {1'b0, in_d.len};
        rk  = {in_d.rk, in_d.dk[tes_pkg::DIV_W-1]};
        rc  = {in_d.rc, in_d.dc[tes_pkg::DIV_W-1]};
        rs  = {in_d.rs, in_d.ds[tes_pkg::DIV_W-1]};
        sk  = rk - dvs;
        sc  = rc - dvs;
        ss  = rs - dvs;
        qk  = (rk >= dvs);
        qc  = (rc >= dvs);
        qs  = (rs >= dvs);
        d_next    = in_d;
        d_next.rk = qk ? sk[tes_pkg::ROOT_W-1:0] : rk[tes_pkg::ROOT_W-1:0];
        d_next.rc = qc ? sc[tes_pkg::ROOT_W-1:0] : rc[tes_pkg::ROOT_W-1:0];
        d_next.rs = qs ? ss[tes_pkg::ROOT_W-1:0] : rs[tes_pkg::ROOT_W-1:0];
        d_next.dk = {in_d.dk[tes_pkg::DIV_W-2:0], qk};
        d_next.dc = {in_d.dc[tes_pkg::DIV_W-2:0], qc};
        d_next.ds = {in_d.ds[tes_pkg::DIV_W-2:0], qs};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_d   = d_reg;

endmodule

[hdl/tes_entry.sv]
// ----------------------------------------------------------------------------
// tes_entry
// Three-stage k * P * Q / 2^60 with sign and 64-bit saturation.
// ----------------------------------------------------------------------------
module tes_entry (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [tes_pkg::DIV_W-1:0]   k,
    input  logic [tes_pkg::PROD_W-1:0]  p,
    input  logic                        neg,
    output logic [63:0]                 value,
    output logic                        sat
);

    logic [62:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic         neg1_reg, neg2_reg;
    logic [126:0] m_next;
    logic [65:0]  q_reg;
    logic [63:0]  value_next, value_reg;
    logic         sat_next, sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg   <= k[31:0]  * p[30:0];
            lh_reg   <= k[31:0]  * p[61:31];
            hl_reg   <= k[63:32] * p[30:0];
            hh_reg   <= k[63:32] * p[61:31];
            neg1_reg <= neg;
        end
    end

    always_comb begin
        m_next = {64'd0, ll_reg}
               + ({64'd0, lh_reg} << 31)
               + ({64'd0, hl_reg} << 32)
               + ({64'd0, hh_reg} << 63);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg    <= m_next[125:60];
            neg2_reg <= neg1_reg;
        end
    end

    always_comb begin
        sat_next   = 1'b0;
        value_next = q_reg[63:0];
        if (neg2_reg) begin
            if (q_reg > {2'b00, 1'b1, 63'd0}) begin
                sat_next   = 1'b1;
                value_next = {1'b1, 63'd0};
            end else begin
                value_next = 64'd0 - q_reg[63:0];
            end
        end else if (q_reg > {3'b000, {63{1'b1}}}) begin
            sat_next   = 1'b1;
            value_next = {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign value = value_reg;
    assign sat   = sat_reg;

endmodule

[tb/truss_element_stiffness_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// truss_element_stiffness_core_tb
// Streams bar elements into the stiffness core with random gaps and output
// stalls, predicts length, the three global stiffness entries and the flags
// of each bar, and compares every output transaction against them in order.
// ----------------------------------------------------------------------------
module truss_element_stiffness_core_tb;

    localparam int LATENCY = 104;

    typedef struct packed {
        logic [31:0] area;
        logic [31:0] modulus;
        logic [31:0] y2;
        logic [31:0] x2;
        logic [31:0] y1;
        logic [31:0] x1;
    } bar_t;

    typedef struct packed {
        logic [4:0]  pad;
        logic        sat;
        logic        zero_len;
        logic [63:0] kss;
        logic [63:0] kcs;
        logic [63:0] kcc;
        logic [32:0] len;
    } stiff_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [231:0] m_tdata;

    bar_t   pending_bars[$];
    stiff_t expected_entries[$];
    int     mismatches = 0;
    bit     stim_done = 1'b0;
    bit     hold_send = 1'b0;
    int     send_wait = 0;
    int     recv_wait = 0;

    truss_element_stiffness_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] clip_entry(logic [63:0] k, logic [61:0] p, bit neg,
                                               ref bit sat);
        logic [127:0] m;
        logic [67:0]  q;
        m = {64'd0, k} * {66'd0, p};
        q = m[127:60];
        if (neg) begin
            if (q > 68'h8000000000000000) begin
                sat = 1'b1;
                return 64'h8000000000000000;
            end
            return -q[63:0];
        end
        if (q > 68'h7FFFFFFFFFFFFFFF) begin
            sat = 1'b1;
            return 64'h7FFFFFFFFFFFFFFF;
        end
        return q[63:0];
    endfunction

    function automatic stiff_t bar_stiffness(bar_t b);
        stiff_t r;
        logic signed [33:0] dx, dy;
        logic [32:0]  ax, ay;
        logic [67:0]  rad;
        logic [67:0]  sq;
        logic [33:0]  len, cand;
        logic [63:0]  k;
        logic [30:0]  cq, sq30;
        bit           sat;
        dx = $signed(b.x2) - $signed(b.x1);
        dy = $signed(b.y2) - $signed(b.y1);
        ax = dx < 0 ? 33'(-dx) : 33'(dx);
        ay = dy < 0 ? 33'(-dy) : 33'(dy);
        rad = {35'd0, ax} * {35'd0, ax} + {35'd0, ay} * {35'd0, ay};
        len = '0;
        for (int i = 33; i >= 0; i--) begin
            cand = len | (34'd1 << i);
            sq = {34'd0, cand} * {34'd0, cand};
            if (sq <= rad) len = cand;
        end
        r = '0;
        r.len = len[32:0];
        if (len == 0) begin
            r.zero_len = 1'b1;
            return r;
        end
        sat = 1'b0;
        k = ({32'd0, b.modulus} * {32'd0, b.area}) / {30'd0, len};
        cq = 31'(({31'd0, ax} << 30) / {30'd0, len});
        sq30 = 31'(({31'd0, ay} << 30) / {30'd0, len});
        r.kcc = clip_entry(k, 62'(cq) * 62'(cq), 1'b0, sat);
        r.kcs = clip_entry(k, 62'(cq) * 62'(sq30),
                           ((dx < 0) != (dy < 0)) && cq != 0 && sq30 != 0, sat);
        r.kss = clip_entry(k, 62'(sq30) * 62'(sq30), 1'b0, sat);
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'(int'($urandom_range(0, 2000)) - 1000);
            3: return 32'(int'($urandom_range(0, 200)) - 100) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_bar(logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                             logic [31:0] y2, logic [31:0] e, logic [31:0] a);
        bar_t b;
        b.x1 = x1; b.y1 = y1; b.x2 = x2; b.y2 = y2; b.modulus = e; b.area = a;
        pending_bars.push_back(b);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) send_wait = $urandom_range(0, 10);
            if (send_wait > 0 && !(s_tvalid && $urandom_range(0, 3) == 0)) begin
                send_wait--;
                s_tvalid <= 1'b0;
            end else if (pending_bars.size() > 0 && !hold_send) begin
                bar_t b;
                b = pending_bars.pop_front();
                s_tdata  <= b;
                s_tvalid <= 1'b1;
                expected_entries.push_back(bar_stiffness(b));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                stiff_t got, want;
                got = m_tdata;
                if (expected_entries.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transaction %h", m_tdata);
                end else begin
                    want = expected_entries.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp len=%h cc=%h cs=%h ss=%h z=%b s=%b",
                                     want.len, want.kcc, want.kcs, want.kss,
                                     want.zero_len, want.sat);
                            $display("          got len=%h cc=%h cs=%h ss=%h z=%b s=%b pad=%h",
                                     got.len, got.kcc, got.kcs, got.kss,
                                     got.zero_len, got.sat, got.pad);
                        end
                    end
                end
                recv_wait = $urandom_range(0, 10);
            end
            if (recv_wait > 0 && $urandom_range(0, 4) != 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        queue_bar(0, 0, 0, 0, 32'h10000, 32'h10000);
        queue_bar(32'h12345678, 32'h80000000, 32'h12345678, 32'h80000000, '1, '1);
        queue_bar(0, 0, 32'h30000, 32'h40000, 32'h10000, 32'h10000);
        queue_bar(0, 0, 32'h30000, 32'hFFFC0000, 32'h20000, 32'h8000);
        queue_bar(0, 0, 32'hFFFD0000, 32'h40000, 32'h20000, 32'h8000);
        queue_bar(0, 0, 32'h10000, 0, 32'h10000, 32'h10000);
        queue_bar(0, 0, 0, 32'hFFFF0000, 32'h10000, 32'h10000);
        queue_bar(0, 0, 32'h1, 0, '1, '1);
        queue_bar(0, 0, 32'h1, 32'hFFFFFFFF, '1, '1);
        queue_bar(0, 0, 32'h1, 32'h1, '1, '1);
        queue_bar(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, '1, '1);
        queue_bar(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, '1, '1);
        queue_bar(32'h80000000, 0, 32'h7FFFFFFF, 0, 32'h1, 32'h1);
        queue_bar(0, 32'h7FFFFFFF, 0, 32'h80000000, '1, '1);
        queue_bar(0, 0, 32'h50000, 32'h50000, 0, 32'h10000);
        queue_bar(0, 0, 32'h50000, 32'h50000, 32'h10000, 0);
        queue_bar(32'h10000, 32'h20000, 32'hFFFF0000, 32'h20000, 32'h1, '1);
        wait (pending_bars.size() == 0);
        for (int i = 0; i < 2000; i++) begin
            if (i == 1000) begin
                wait (pending_bars.size() == 0);
                hold_send = 1'b1;
                wait (expected_entries.size() == 0);
                @(posedge aclk);
                hold_send = 1'b0;
            end
            if ($urandom_range(0, 30) == 0)
                queue_bar(pick_word(), pick_word(), 0, 0, pick_word(), pick_word());
            else
                queue_bar(pick_word(), pick_word(), pick_word(), pick_word(),
                          pick_word(), pick_word());
            if (pending_bars.size() > 8) wait (pending_bars.size() <= 4);
        end
        wait (pending_bars.size() == 0 && !s_tvalid);
        wait (expected_entries.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && expected_entries.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
